// ----- rtl/core/dlr_pkg.sv -----
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared constants and types for the dda line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 2;

    // operation codes of an input request
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic {
        BACK_IDLE,
        BACK_DIV
    } t_back_state;

endpackage

// ----- rtl/core/dlr_front.sv -----
// ----------------------------------------------------------------------------
// dlr_front
// Classifies an incoming request: endpoint deltas, their signs and the step
// count, packed into one command word for the queue.
// ----------------------------------------------------------------------------
module dlr_front #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    localparam int CMD_W     = 5 * COORD_BITS + 4
) (
    input  logic                  i_operation,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic                  i_erase_mode,
    output logic [CMD_W-1:0]      o_cmd
);

    logic                  x_neg;
    logic                  y_neg;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] steps;

    always_comb begin
        x_neg = i_end_x < i_start_x;
        y_neg = i_end_y < i_start_y;
        adx   = x_neg ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        ady   = y_neg ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        steps = (adx > ady) ? adx : ady;
        o_cmd = {i_operation, i_erase_mode, i_start_x, i_start_y, steps, adx, ady,
                 x_neg, y_neg};
    end

endmodule

// ----- rtl/core/dlr_queue.sv -----
// ----------------------------------------------------------------------------
// dlr_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module dlr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dlr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/dlr_div.sv -----
// ----------------------------------------------------------------------------
// dlr_div
// Restoring divider, one quotient bit per cycle, x and y side by side.
// Computes mag * 2^FRAC_BITS / steps for mag <= steps.
// ----------------------------------------------------------------------------
module dlr_div #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_steps,
    input  logic [COORD_BITS-1:0] i_x_mag,
    input  logic [COORD_BITS-1:0] i_y_mag,
    output logic                  o_done,
    output logic [FRAC_BITS:0]    o_x_quot,
    output logic [FRAC_BITS:0]    o_y_quot
);

    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic [COORD_BITS-1:0] r_div;
    logic [COORD_BITS:0]   r_x_rem;
    logic [COORD_BITS:0]   r_y_rem;
    logic [FRAC_BITS:0]    r_x_quot;
    logic [FRAC_BITS:0]    r_y_quot;
    logic                  x_bit;
    logic                  y_bit;
    logic [COORD_BITS:0]   x_diff;
    logic [COORD_BITS:0]   y_diff;

    always_comb begin
        x_bit  = r_x_rem >= {1'b0, r_div};
        y_bit  = r_y_rem >= {1'b0, r_div};
        // remainder stays below the divisor, so the shift fits
        x_diff = (x_bit ? (r_x_rem - {1'b0, r_div}) : r_x_rem) << 1;
        y_diff = (y_bit ? (r_y_rem - {1'b0, r_div}) : r_y_rem) << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(FRAC_BITS + 1);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div    <= i_steps;
            r_x_rem  <= {1'b0, i_x_mag};
            r_y_rem  <= {1'b0, i_y_mag};
            r_x_quot <= '0;
            r_y_quot <= '0;
        end else if (r_cnt != '0) begin
            r_x_rem  <= x_diff;
            r_y_rem  <= y_diff;
            r_x_quot <= {r_x_quot[FRAC_BITS-1:0], x_bit};
            r_y_quot <= {r_y_quot[FRAC_BITS-1:0], y_bit};
        end
    end

    assign o_done   = r_done;
    assign o_x_quot = r_x_quot;
    assign o_y_quot = r_y_quot;

endmodule

// ----- rtl/core/dlr_back.sv -----
// ----------------------------------------------------------------------------
// dlr_back
// Carries out queued commands: line setup through the divider, then one
// pixel per step request into the output register.
// ----------------------------------------------------------------------------
module dlr_back #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF,
    localparam int CMD_W     = 5 * COORD_BITS + 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [CMD_W-1:0]      i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_pixel_on,
    output logic                  o_last_pixel
);

    localparam int ACC_W  = COORD_BITS + FRAC_BITS;
    localparam int STEP_W = FRAC_BITS + 2;

    logic                  c_op;
    logic                  c_erase;
    logic [COORD_BITS-1:0] c_sx;
    logic [COORD_BITS-1:0] c_sy;
    logic [COORD_BITS-1:0] c_steps;
    logic [COORD_BITS-1:0] c_adx;
    logic [COORD_BITS-1:0] c_ady;
    logic                  c_x_neg;
    logic                  c_y_neg;

    dlr_pkg::t_back_state  r_state;
    dlr_pkg::t_back_state  n_state;
    logic [ACC_W-1:0]      r_x_acc;
    logic [ACC_W-1:0]      r_y_acc;
    logic [STEP_W-1:0]     r_x_inc;
    logic [STEP_W-1:0]     r_y_inc;
    logic [COORD_BITS-1:0] r_left;
    logic                  r_erase;
    logic                  r_x_neg;
    logic                  r_y_neg;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic                  r_pon;
    logic                  r_last;

    logic                  out_free;
    logic                  pop;
    logic                  emit;
    logic                  div_start;
    logic                  div_done;
    logic [FRAC_BITS:0]    x_quot;
    logic [FRAC_BITS:0]    y_quot;
    logic [STEP_W-1:0]     x_mag_inc;
    logic [STEP_W-1:0]     y_mag_inc;

    assign {c_op, c_erase, c_sx, c_sy, c_steps, c_adx, c_ady, c_x_neg, c_y_neg} = i_q_cmd;
    assign out_free = !r_out_valid || !i_out_stall;

    dlr_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_steps  (c_steps),
        .i_x_mag  (c_adx),
        .i_y_mag  (c_ady),
        .o_done   (div_done),
        .o_x_quot (x_quot),
        .o_y_quot (y_quot)
    );

    always_comb begin
        n_state   = r_state;
        pop       = 1'b0;
        emit      = 1'b0;
        div_start = 1'b0;
        case (r_state)
            dlr_pkg::BACK_IDLE: begin
                if (i_q_valid) begin
                    if (c_op == dlr_pkg::OP_START) begin
                        pop = 1'b1;
                        if (c_steps != '0) begin
                            div_start = 1'b1;
                            n_state   = dlr_pkg::BACK_DIV;
                        end
                    end else if (r_left == '0) begin
                        // step with no line in progress is dropped
                        pop = 1'b1;
                    end else if (out_free) begin
                        pop  = 1'b1;
                        emit = 1'b1;
                    end
                end
            end
            dlr_pkg::BACK_DIV: begin
                if (div_done) begin
                    n_state = dlr_pkg::BACK_IDLE;
                end
            end
            default: begin
                n_state = dlr_pkg::BACK_IDLE;
            end
        endcase
    end

    always_comb begin
        x_mag_inc = {1'b0, x_quot};
        y_mag_inc = {1'b0, y_quot};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlr_pkg::BACK_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop && c_op == dlr_pkg::OP_START) begin
                r_left <= c_steps;
            end else if (emit) begin
                r_left <= r_left - 1'b1;
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && c_op == dlr_pkg::OP_START) begin
            r_erase <= c_erase;
            r_x_neg <= c_x_neg;
            r_y_neg <= c_y_neg;
            r_x_acc <= {c_sx, {FRAC_BITS{1'b0}}};
            r_y_acc <= {c_sy, {FRAC_BITS{1'b0}}};
            r_x_inc <= '0;
            r_y_inc <= '0;
        end else begin
            if (div_done) begin
                r_x_inc <= r_x_neg ? (STEP_W'(0) - x_mag_inc) : x_mag_inc;
                r_y_inc <= r_y_neg ? (STEP_W'(0) - y_mag_inc) : y_mag_inc;
            end
            if (emit) begin
                r_x_acc <= r_x_acc + {{(ACC_W-STEP_W){r_x_inc[STEP_W-1]}}, r_x_inc};
                r_y_acc <= r_y_acc + {{(ACC_W-STEP_W){r_y_inc[STEP_W-1]}}, r_y_inc};
            end
        end
        if (emit) begin
            r_px   <= r_x_acc[ACC_W-1:FRAC_BITS];
            r_py   <= r_y_acc[ACC_W-1:FRAC_BITS];
            r_pon  <= !r_erase;
            r_last <= r_left == COORD_BITS'(1);
        end
    end

    assign o_q_pop      = pop;
    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_pixel_on   = r_pon;
    assign o_last_pixel = r_last;

endmodule

// ----- rtl/core/dda_line_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// DDA line rasterizer: a start request latches a line, each step request
// yields the next pixel of it.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------
//  in      | to block  | i_in_valid / o_in_stall     | operation, endpoints,
//          |           |                             | erase_mode
//  out     | from block| o_out_valid / i_out_stall   | pixel_x/y, pixel_on,
//          |           |                             | last_pixel
//
// Step requests run at one pixel per cycle through the command queue and
// the output register, while the output is not stalled and no divide runs.
// A start request with a nonzero length holds the back end in its divide
// state until the bit-serial divider is done and the increments are loaded.
// Reset is synchronous, active low; it empties the queue and goes idle.
// A stall on the output fills the queue, after which o_in_stall rises.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic                  i_erase_mode,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_pixel_on,
    output logic                  o_last_pixel
);

    localparam int CMD_W = 5 * COORD_BITS + 4;

    logic [CMD_W-1:0] front_cmd;
    logic [CMD_W-1:0] q_cmd;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    dlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_operation  (i_operation),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_erase_mode (i_erase_mode),
        .o_cmd        (front_cmd)
    );

    dlr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (dlr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    dlr_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_on   (o_pixel_on),
        .o_last_pixel (o_last_pixel)
    );

    assign o_in_stall = q_full;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dda_line_rasterizer_unit. A line tracker in the
// bench mirrors the accumulators of each accepted request and queues the
// pixel that every step request should produce. The result monitor compares
// each accepted pixel field by field. Directed lines come first, then random
// line sequences under three idle patterns, a long output hold and a drain.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CB = dlr_pkg::COORD_BITS_DEF;
    localparam int FB = dlr_pkg::FRAC_BITS_DEF;
    localparam int AB = CB + FB;
    localparam int SB = FB + 2;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          on;
        logic          last;
    } t_pixel;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          i_operation = dlr_pkg::OP_START;
    logic [CB-1:0] i_start_x = '0;
    logic [CB-1:0] i_start_y = '0;
    logic [CB-1:0] i_end_x = '0;
    logic [CB-1:0] i_end_y = '0;
    logic          i_erase_mode = 1'b0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic [CB-1:0] o_pixel_x;
    logic [CB-1:0] o_pixel_y;
    logic          o_pixel_on;
    logic          o_last_pixel;

    // line tracker state
    logic [AB-1:0] x_acc = '0;
    logic [AB-1:0] y_acc = '0;
    logic [SB-1:0] x_inc = '0;
    logic [SB-1:0] y_inc = '0;
    logic [CB-1:0] pixels_to_go = '0;
    logic          erase_latched = 1'b0;

    t_pixel pending_pixels[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int errors = 0;
    int pixels_checked = 0;
    int lines_started = 0;
    int in_stall_cycles = 0;

    dda_line_rasterizer_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_erase_mode (i_erase_mode),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_on   (o_pixel_on),
        .o_last_pixel (o_last_pixel)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // signed per-pixel increment, truncated toward zero
    function automatic logic [SB-1:0] slope_inc(input logic [CB-1:0] a_pos,
                                                input logic [CB-1:0] b_pos,
                                                input logic [CB-1:0] steps);
        logic [AB-1:0] mag;
        logic [AB-1:0] quo;
        mag = (b_pos < a_pos) ? AB'(a_pos - b_pos) : AB'(b_pos - a_pos);
        quo = (mag << FB) / AB'(steps);
        if (b_pos < a_pos)
            quo = -quo;
        return quo[SB-1:0];
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < 0)
            return 0;
        if (v > int'(CMAX))
            return int'(CMAX);
        return v;
    endfunction

    task automatic advance_raster(input logic op, input logic [CB-1:0] sx,
                                  input logic [CB-1:0] sy, input logic [CB-1:0] ex,
                                  input logic [CB-1:0] ey, input logic er);
        logic [CB-1:0] adx;
        logic [CB-1:0] ady;
        logic [CB-1:0] steps;
        if (op == dlr_pkg::OP_START) begin
            lines_started++;
            adx = (ex > sx) ? ex - sx : sx - ex;
            ady = (ey > sy) ? ey - sy : sy - ey;
            steps = (adx > ady) ? adx : ady;
            erase_latched = er;
            x_acc = {sx, {FB{1'b0}}};
            y_acc = {sy, {FB{1'b0}}};
            pixels_to_go = steps;
            if (steps == 0) begin
                x_inc = '0;
                y_inc = '0;
            end else begin
                x_inc = slope_inc(sx, ex, steps);
                y_inc = slope_inc(sy, ey, steps);
            end
        end else if (pixels_to_go != 0) begin
            pending_pixels.push_back('{x: x_acc[AB-1:FB], y: y_acc[AB-1:FB],
                                       on: ~erase_latched,
                                       last: (pixels_to_go == 1)});
            x_acc = x_acc + {{(AB-SB){x_inc[SB-1]}}, x_inc};
            y_acc = y_acc + {{(AB-SB){y_inc[SB-1]}}, y_inc};
            pixels_to_go = pixels_to_go - 1'b1;
        end
    endtask

    // offer one request and return once it is accepted and o_in_stall is low
    task automatic send_request(input logic op, input logic [CB-1:0] sx,
                                input logic [CB-1:0] sy, input logic [CB-1:0] ex,
                                input logic [CB-1:0] ey, input logic er);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_start_x    <= sx;
        i_start_y    <= sy;
        i_end_x      <= ex;
        i_end_y      <= ey;
        i_erase_mode <= er;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        advance_raster(op, sx, sy, ex, ey, er);
    endtask

    // step request with junk in the ignored fields
    task automatic send_step();
        send_request(dlr_pkg::OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom),
                     CB'($urandom), 1'($urandom));
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_pixels.size() != 0);
    endtask

    // receiver: random stall, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall)
                in_stall_cycles++;
            if (o_out_valid && !i_out_stall) begin
                if (pending_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pixel x=%0d y=%0d on=%0d last=%0d",
                             $time, o_pixel_x, o_pixel_y, o_pixel_on, o_last_pixel);
                end else begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (o_pixel_x !== want.x) begin
                        errors++;
                        $display("%0t: pixel_x expected %0d got %0d",
                                 $time, want.x, o_pixel_x);
                    end
                    if (o_pixel_y !== want.y) begin
                        errors++;
                        $display("%0t: pixel_y expected %0d got %0d",
                                 $time, want.y, o_pixel_y);
                    end
                    if (o_pixel_on !== want.on) begin
                        errors++;
                        $display("%0t: pixel_on expected %0d got %0d",
                                 $time, want.on, o_pixel_on);
                    end
                    if (o_last_pixel !== want.last) begin
                        errors++;
                        $display("%0t: last_pixel expected %0d got %0d",
                                 $time, want.last, o_last_pixel);
                    end
                end
            end
        end
    end

    // steps while idle and zero-length lines give nothing
    task automatic test_idle_and_empty();
        send_step();
        send_request(dlr_pkg::OP_START, 10'd512, 10'd512, 10'd512, 10'd512, 1'b1);
        send_step();
        send_request(dlr_pkg::OP_START, CMAX, 10'd0, CMAX, 10'd0, 1'b0);
        send_step();
    endtask

    task automatic test_short_lines();
        send_request(dlr_pkg::OP_START, 10'd0, 10'd0, 10'd1, 10'd0, 1'b0);
        repeat (2) send_step();
        send_request(dlr_pkg::OP_START, CMAX, CMAX, CMAX - 1'b1, CMAX - 1'b1, 1'b1);
        send_step();
        send_request(dlr_pkg::OP_START, 10'd5, 10'd5, 10'd9, 10'd2, 1'b1);
        repeat (5) send_step();
    endtask

    // a start in the middle of a line replaces it
    task automatic test_restart();
        send_request(dlr_pkg::OP_START, CMAX, 10'd0, 10'd0, CMAX, 1'b0);
        repeat (3) send_step();
        send_request(dlr_pkg::OP_START, 10'd0, CMAX, 10'd2, CMAX - 10'd3, 1'b1);
        repeat (4) send_step();
    endtask

    // output held off while steps keep coming, so the input side backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_request(dlr_pkg::OP_START, 10'd100, 10'd900, 10'd400, 10'd650, 1'b0);
        hold_left = 200;
        repeat (301) send_step();
        pause_until_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int done_items;
        int span;
        int sx;
        int sy;
        int ex;
        int ey;
        int len;
        int n_steps;
        done_items = 0;
        while (done_items < n_items) begin
            case ($urandom_range(0, 19))
                0:       span = int'(CMAX);
                1, 2, 3: span = 80;
                default: span = 10;
            endcase
            sx = $urandom_range(0, int'(CMAX));
            sy = $urandom_range(0, int'(CMAX));
            ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
            ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
            if ($urandom_range(0, 19) == 0) begin
                ex = sx;
                ey = sy;
            end
            len = (ex > sx) ? ex - sx : sx - ex;
            if (((ey > sy) ? ey - sy : sy - ey) > len)
                len = (ey > sy) ? ey - sy : sy - ey;
            // mostly full lines plus maybe an idle step; else up to 60 steps, often cut short by a restart
            if ($urandom_range(0, 9) < 8 && len <= 100)
                n_steps = len + $urandom_range(0, 1);
            else
                n_steps = $urandom_range(0, (len < 60) ? len : 60);
            send_request(dlr_pkg::OP_START, CB'(sx), CB'(sy), CB'(ex), CB'(ey),
                         1'($urandom_range(0, 1)));
            repeat (n_steps) send_step();
            done_items += n_steps + 1;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_empty();
        test_short_lines();
        test_restart();
        pause_until_drained();

        send_idle_pct = 32;
        recv_idle_pct = 74;
        test_random_traffic(450);
        pause_until_drained();

        test_backpressure();

        send_idle_pct = 74;
        recv_idle_pct = 32;
        test_random_traffic(450);
        pause_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(450);

        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (FB + 10) @(posedge i_clk);

        $display("covered %0d lines and %0d checked pixels, %0d input stall cycles",
                 lines_started, pixels_checked, in_stall_cycles);
        $display("idle patterns: sender-heavy, receiver-heavy, none; one long output hold");
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/dlr_pkg.sv
rtl/core/dlr_front.sv
rtl/core/dlr_queue.sv
rtl/core/dlr_div.sv
rtl/core/dlr_back.sv
rtl/core/dda_line_rasterizer_unit.sv
test/testbench.sv
